>>> rtl/cprq_pkg.sv
// Shared types and codes for the clock page replacement queue.
package cprq_pkg;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_REF    = 2'd2;

  // Width of the page number field on the ports
  localparam int unsigned PORT_PAGE_BITS = 20;

  // Per-cell command from the queue controller
  typedef struct packed {
    logic shift;    // take page and reference bit from the next cell
    logic load;     // take the request page, reference bit clear
    logic set_ref;  // mark the held page referenced
    logic clr_ref;  // clear the reference bit (vacated tail)
  } cell_ctl_t;

endpackage

>>> rtl/cprq_cell.sv
// One queue slot: a page number, its reference bit and a match compare.
module cprq_cell
  import cprq_pkg::*;
#(
  parameter int unsigned PAGE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic [PAGE_BITS-1:0] key_page,
  input  logic [PAGE_BITS-1:0] nbr_page,
  input  logic                 nbr_ref,
  output logic [PAGE_BITS-1:0] page_o,
  output logic                 ref_o,
  output logic                 match_o
);

  logic [PAGE_BITS-1:0] page_r;
  logic                 ref_r;

  // Load or shift the page; no reset needed on payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      page_r <= key_page;
    end else if (ctl.shift) begin
      page_r <= nbr_page;
    end
  end

  // Update the reference bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= 1'b0;
    end else if (ctl.load || ctl.clr_ref) begin
      ref_r <= 1'b0;
    end else if (ctl.shift) begin
      ref_r <= nbr_ref;
    end else if (ctl.set_ref) begin
      ref_r <= 1'b1;
    end
  end

  assign page_o  = page_r;
  assign ref_o   = ref_r;
  assign match_o = (page_r == key_page);

endmodule

>>> rtl/clock_page_replacement_queue.sv
// Clock page replacement queue: controller and a row of page cells.
//
// Usage: requests arrive on the in_ channel (opcode on in_tuser, page number
// on in_tdata) and each produces exactly one result on the out_ channel
// (evict_valid and status on out_tuser, evicted page and occupancy on
// out_tdata). Cell 0 always holds the oldest page; the queue is kept packed
// toward cell 0, so a rotation or a removal shifts the row by one cell.
// A remove or reference scans the occupied cells from cell 0 until it finds
// the page or passes the last one; an insert into a full queue first moves
// each referenced page at cell 0 to the tail with its reference bit cleared,
// then evicts the first unreferenced page. An insert into a non-full queue,
// a remove or reference on an empty queue and an unused opcode need no scan.
// The row handles one request at a time: in_tready is high only while idle,
// so the next request can be taken in the cycle after the result enters
// the output register. A finished result waits in the output register while
// the receiver stalls; the controller holds the next result, and with it the
// input, until that register is free. Synchronous reset empties the queue
// and clears every reference bit; page contents are left as they are.
module clock_page_replacement_queue
  import cprq_pkg::*;
#(
  parameter int unsigned CLOCK_DEPTH = 8,
  parameter int unsigned PAGE_BITS   = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] page_number, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [19:0] evicted_page, [23:20] occupancy
  output logic [1:0]  out_tuser   // [0] evict_valid, [1] status
);

  localparam int unsigned CW = $clog2(CLOCK_DEPTH + 1);
  localparam int unsigned IW = (CLOCK_DEPTH > 1) ? $clog2(CLOCK_DEPTH) : 1;
  localparam int unsigned KB = (PAGE_BITS < PORT_PAGE_BITS) ? PAGE_BITS : PORT_PAGE_BITS;
  localparam logic [CW-1:0] FULL = CW'(CLOCK_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           op_r;
  logic [PAGE_BITS-1:0] key_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 res_evict_r, res_evict_nxt;
  logic                 res_status_r, res_status_nxt;
  logic [PAGE_BITS-1:0] res_page_r, res_page_nxt;
  logic                 out_tvalid_r;
  logic [PORT_PAGE_BITS-1:0] out_page_r;
  logic                 out_evict_r, out_status_r;
  logic [3:0]           out_occ_r;

  logic [PAGE_BITS-1:0] cell_page [CLOCK_DEPTH];
  logic                 cell_ref  [CLOCK_DEPTH];
  logic [CLOCK_DEPTH-1:0] match_vec;
  cell_ctl_t            cell_ctl  [CLOCK_DEPTH];

  // Row-wide commands decided by the controller
  logic                 do_load, do_rotate, do_evict, do_remove, do_setref;
  logic [PAGE_BITS-1:0] tail_page;
  logic                 in_acc, push;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign push      = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign tail_page = do_rotate ? cell_page[0] : key_r;

  // Cell row
  for (genvar i = 0; i < CLOCK_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] POS = CW'(i);
    logic [PAGE_BITS-1:0] nbr_page;
    logic                 nbr_ref;

    if (i == CLOCK_DEPTH - 1) begin : g_tail
      assign nbr_page = tail_page;
      assign nbr_ref  = 1'b0;
    end else begin : g_mid
      assign nbr_page = cell_page[i+1];
      assign nbr_ref  = cell_ref[i+1];
    end

    always_comb begin
      cell_ctl[i].load    = do_load && (POS == count_r);
      cell_ctl[i].shift   = do_rotate || do_evict ||
                            (do_remove && (POS >= CW'(idx_r)) && (POS + 1'b1 < count_r));
      cell_ctl[i].clr_ref = do_remove && (POS + 1'b1 == count_r);
      cell_ctl[i].set_ref = do_setref && (IW'(i) == idx_r);
    end

    cprq_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl[i]),
      .key_page (key_r),
      .nbr_page (nbr_page),
      .nbr_ref  (nbr_ref),
      .page_o   (cell_page[i]),
      .ref_o    (cell_ref[i]),
      .match_o  (match_vec[i])
    );
  end

  // Sequence one request through the row
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_evict_nxt  = res_evict_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    do_load        = 1'b0;
    do_rotate      = 1'b0;
    do_evict       = 1'b0;
    do_remove      = 1'b0;
    do_setref      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_evict_nxt  = 1'b0;
        res_status_nxt = 1'b0;
        res_page_nxt   = '0;
        idx_nxt        = '0;
        state_nxt      = S_DONE;
        if (op_r == OP_INSERT) begin
          if (count_r == FULL) begin
            state_nxt = S_EVICT;
          end else begin
            do_load   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end else if (op_r == OP_REMOVE || op_r == OP_REF) begin
          if (count_r == '0) begin
            res_status_nxt = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_EVICT: begin
        if (cell_ref[0]) begin
          do_rotate = 1'b1;
        end else begin
          do_evict      = 1'b1;
          res_evict_nxt = 1'b1;
          res_page_nxt  = cell_page[0];
          state_nxt     = S_DONE;
        end
      end
      S_SCAN: begin
        if (match_vec[idx_r]) begin
          state_nxt = S_DONE;
          if (op_r == OP_REMOVE) begin
            do_remove = 1'b1;
            count_nxt = count_r - 1'b1;
          end else begin
            do_setref = 1'b1;
          end
        end else if (CW'(idx_r) + 1'b1 == count_r) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (push) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (push) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Request and result payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      key_r <= PAGE_BITS'(in_tdata[KB-1:0]);
    end
    idx_r        <= idx_nxt;
    res_evict_r  <= res_evict_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    if (push) begin
      out_evict_r  <= res_evict_r;
      out_status_r <= res_status_r;
      out_page_r   <= PORT_PAGE_BITS'(res_page_r);
      out_occ_r    <= 4'(count_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_occ_r, out_page_r};
  assign out_tuser  = {out_status_r, out_evict_r};

  // Occupancy never exceeds the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("occupancy above queue depth");

  // Eviction only runs on a full queue
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVICT |-> count_r == FULL)
    else $error("eviction on a non-full queue");

  // Scan stays inside the occupied cells
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CW'(idx_r) < count_r)
    else $error("scan past occupied cells");

  // An eviction result leaves the queue full
  a_evict_occ: assert property (@(posedge clk) disable iff (!rst_n)
    push && res_evict_r |-> count_r == FULL)
    else $error("evicting insert left queue not full");

  // A result is pushed only when the output register is free
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !out_tvalid_r || out_tready)
    else $error("result overwrote a waiting result");

endmodule
